FILE: rtl/core/vmau_pkg.sv
`default_nettype none

package vmau_pkg;

  // Register file geometry
  localparam int VLEN_BYTES = 16;
  localparam int NUM_VREGS  = 32;
  localparam int FILE_BYTES = NUM_VREGS * VLEN_BYTES;
  localparam int ADDR_W     = $clog2(FILE_BYTES);
  localparam int VB_W       = $clog2(VLEN_BYTES);
  localparam int VREG_W     = $clog2(NUM_VREGS);

  // Stream widths
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 16;

  // Configuration register indexes
  localparam logic [2:0] CFG_SEW    = 3'd0;
  localparam logic [2:0] CFG_LMUL   = 3'd1;
  localparam logic [2:0] CFG_VL     = 3'd2;
  localparam logic [2:0] CFG_START  = 3'd3;
  localparam logic [2:0] CFG_XBYTES = 3'd4;

  // Request kinds
  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_ADD_VV = 3'd2,
    OP_ADD_VI = 3'd3,
    OP_ADD_VX = 3'd4
  } op_t;

  typedef struct packed {
    op_t         req_type;
    logic [4:0]  dest_reg;
    logic [4:0]  src_a_reg;
    logic [4:0]  src_b_reg;
    logic [4:0]  immediate;
    logic [63:0] scalar_value;
    logic        unmasked;
    logic [3:0]  byte_offset;
    logic [7:0]  write_byte;
  } req_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic clr_step;
    logic acc_byte;
    logic latch_rd;
    logic rd_mask;
    logic rd_a;
    logic rd_b;
    logic wr_sum;
    logic skip_elem;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_read;
    logic is_vv;
    logic unmasked;
    logic elem_done;
    logic mask_bit;
    logic last_byte;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/vmau_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data
module vmau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/vmau_dp.sv
`default_nettype none

module vmau_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [7:0]     cfg_data,
  input  wire vmau_pkg::req_t req,
  input  wire vmau_pkg::cmd_t cmd,
  output vmau_pkg::sts_t      sts,
  output logic [7:0]          read_byte
);

  import vmau_pkg::*;

  // Configuration registers
  logic [1:0] sew_log2;
  logic [2:0] lmul_log2;
  logic [7:0] vl;
  logic [6:0] vstart;
  logic [3:0] xbytes;

  // Request and loop state
  req_t              req_q;
  logic [7:0]        elem;
  logic [2:0]        bsel;
  logic              carry;
  logic [7:0]        a_q;
  logic [7:0]        rd_q;
  logic [ADDR_W-1:0] clr_cnt;

  // RAM port signals
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // Address generation
  logic [2:0]        eprl;
  logic [7:0]        slot;
  logic [7:0]        group;
  logic [VB_W-1:0]   elem_byte;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [ADDR_W-1:0] addr_d;
  logic [ADDR_W-1:0] addr_mask;
  logic [ADDR_W-1:0] addr_byte;
  logic [3:0]        sew_n;

  // Operand generation
  logic [3:0] xb_c;
  logic [2:0] xb_top;
  logic       x_hi;
  logic [7:0] imm_hi;
  logic [7:0] imm_lo;
  logic [7:0] a_val;
  logic [7:0] o_val;
  logic [8:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      sew_log2  <= '0;
      lmul_log2 <= '0;
      vl        <= '0;
      vstart    <= '0;
      xbytes    <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEW:    sew_log2  <= cfg_data[1:0];
        CFG_LMUL:   lmul_log2 <= cfg_data[2:0];
        CFG_VL:     vl        <= cfg_data;
        CFG_START:  vstart    <= cfg_data[6:0];
        CFG_XBYTES: xbytes    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Elements per register as log2, saturated at one element
  always_comb begin
    int neg;
    int eprl_i;
    neg = lmul_log2[2] ? (8 - int'(lmul_log2)) : 0;
    eprl_i = VB_W - int'(sew_log2) - neg;
    if (eprl_i < 0) begin
      eprl_i = 0;
    end
    eprl = 3'(eprl_i);
  end

  assign sew_n     = 4'd1 << sew_log2;
  assign slot      = elem & ~(8'hff << eprl);
  assign group     = elem >> eprl;
  assign elem_byte = VB_W'((slot << sew_log2) + {5'd0, bsel});
  assign addr_a    = {req_q.src_a_reg + group[VREG_W-1:0], elem_byte};
  assign addr_b    = {req_q.src_b_reg + group[VREG_W-1:0], elem_byte};
  assign addr_d    = {req_q.dest_reg + group[VREG_W-1:0], elem_byte};
  assign addr_mask = ADDR_W'(elem[7:3]);
  assign addr_byte = {req_q.dest_reg, VB_W'(req_q.byte_offset)};

  // Immediate and scalar operand bytes, sign extended
  assign imm_hi = req_q.immediate[4] ? 8'hff : 8'h00;
  assign imm_lo = {imm_hi[7:5], req_q.immediate};
  assign xb_c   = (xbytes == 4'd0) ? 4'd1 : ((xbytes > 4'd8) ? 4'd8 : xbytes);
  assign xb_top = 3'(xb_c - 4'd1);
  assign x_hi   = req_q.scalar_value[{xb_top, 3'b111}];

  always_comb begin
    a_val = ram_rdata;
    o_val = ram_rdata;
    case (req_q.req_type)
      OP_ADD_VV: begin
        a_val = a_q;
        o_val = ram_rdata;
      end
      OP_ADD_VI: begin
        o_val = (bsel == 3'd0) ? imm_lo : imm_hi;
      end
      OP_ADD_VX: begin
        o_val = ({1'b0, bsel} < xb_c) ? req_q.scalar_value[{bsel, 3'b000} +: 8]
                                       : {8{x_hi}};
      end
      default: ;
    endcase
  end

  assign sum = {1'b0, a_val} + {1'b0, o_val} + {8'd0, carry};

  // Status back to controller
  assign sts.clear_last = (clr_cnt == ADDR_W'(FILE_BYTES - 1));
  assign sts.is_read    = (req_q.req_type == OP_READ);
  assign sts.is_vv      = (req_q.req_type == OP_ADD_VV);
  assign sts.unmasked   = req_q.unmasked;
  assign sts.elem_done  = (elem >= vl);
  assign sts.mask_bit   = ram_rdata[elem[2:0]];
  assign sts.last_byte  = ({1'b0, bsel} == (sew_n - 4'd1));

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // Request capture and element/byte walk
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
      elem  <= {1'b0, vstart};
      bsel  <= '0;
      carry <= 1'b0;
    end else if (cmd.wr_sum) begin
      if (sts.last_byte) begin
        elem  <= elem + 8'd1;
        bsel  <= '0;
        carry <= 1'b0;
      end else begin
        bsel  <= bsel + 3'd1;
        carry <= sum[8];
      end
    end else if (cmd.skip_elem) begin
      elem <= elem + 8'd1;
    end
    if (cmd.rd_b) begin
      a_q <= ram_rdata;
    end
    if (cmd.latch_rd) begin
      rd_q <= ram_rdata;
    end
    if (cmd.finish) begin
      read_byte <= sts.is_read ? rd_q : 8'd0;
    end
  end

  // RAM port muxing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_d;
    ram_wdata = sum[7:0];
    ram_raddr = addr_byte;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = 8'd0;
    end else if (cmd.acc_byte && (req_q.req_type == OP_WRITE)) begin
      ram_we    = 1'b1;
      ram_waddr = addr_byte;
      ram_wdata = req_q.write_byte;
    end else if (cmd.wr_sum) begin
      ram_we = 1'b1;
    end
    if (cmd.rd_mask) begin
      ram_raddr = addr_mask;
    end else if (cmd.rd_b) begin
      ram_raddr = addr_b;
    end else if (cmd.rd_a) begin
      ram_raddr = addr_a;
    end
  end

  vmau_ram #(
    .WIDTH (8),
    .DEPTH (FILE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: rtl/core/vmau_ctrl.sv
`default_nettype none

module vmau_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  input  wire logic [2:0]     s_tuser,
  output logic                s_tready,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output vmau_pkg::cmd_t      cmd,
  input  wire vmau_pkg::sts_t sts
);

  import vmau_pkg::*;

  typedef enum logic [9:0] {
    ST_CLEAR    = 10'b00_0000_0001,
    ST_IDLE     = 10'b00_0000_0010,
    ST_BYTE_ACC = 10'b00_0000_0100,
    ST_BYTE_LAT = 10'b00_0000_1000,
    ST_ELEM     = 10'b00_0001_0000,
    ST_MASK     = 10'b00_0010_0000,
    ST_RD_A     = 10'b00_0100_0000,
    ST_RD_B     = 10'b00_1000_0000,
    ST_WR       = 10'b01_0000_0000,
    ST_FINISH   = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    m_tvalid_next = m_tvalid && !m_tready;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          case (s_tuser) inside
            OP_WRITE, OP_READ:               state_next = ST_BYTE_ACC;
            OP_ADD_VV, OP_ADD_VI, OP_ADD_VX: state_next = ST_ELEM;
            default:                         state_next = ST_FINISH;
          endcase
        end
      end
      ST_BYTE_ACC: begin
        cmd.acc_byte = 1'b1;
        state_next   = sts.is_read ? ST_BYTE_LAT : ST_FINISH;
      end
      ST_BYTE_LAT: begin
        cmd.latch_rd = 1'b1;
        state_next   = ST_FINISH;
      end
      // Next element: stop at vl, otherwise fetch its mask byte if needed
      ST_ELEM: begin
        if (sts.elem_done) begin
          state_next = ST_FINISH;
        end else if (sts.unmasked) begin
          state_next = ST_RD_A;
        end else begin
          cmd.rd_mask = 1'b1;
          state_next  = ST_MASK;
        end
      end
      ST_MASK: begin
        if (sts.mask_bit) begin
          state_next = ST_RD_A;
        end else begin
          cmd.skip_elem = 1'b1;
          state_next    = ST_ELEM;
        end
      end
      ST_RD_A: begin
        cmd.rd_a   = 1'b1;
        state_next = sts.is_vv ? ST_RD_B : ST_WR;
      end
      ST_RD_B: begin
        cmd.rd_b   = 1'b1;
        state_next = ST_WR;
      end
      ST_WR: begin
        cmd.wr_sum = 1'b1;
        state_next = sts.last_byte ? ST_ELEM : ST_RD_A;
      end
      // Hand the result to the output register once it is free
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vector_masked_add_unit.sv
`default_nettype none

// Channel   Dir  Transaction fields
// s_*       in   tuser: req_type; tdata: dest_reg, src_a_reg, src_b_reg, immediate,
//                scalar_value, unmasked, byte_offset, write_byte
// m_*       out  tdata: read_byte, done_res
// cfg_*     in   cfg_index selects the register, cfg_data is written when cfg_we
//
// After reset the 512-byte register file is zeroed, one byte per cycle, and s_tready
// stays low during that sweep. To m_tvalid: byte write ST_BYTE_ACC, ST_FINISH; byte
// read ST_BYTE_ACC, ST_BYTE_LAT, ST_FINISH; unknown kind ST_FINISH. Add: ST_ELEM per
// element (and ST_MASK if masked), then ST_RD_A, ST_RD_B (vv) and ST_WR per SEW byte,
// then ST_FINISH; a clear mask bit skips the element. Each byte is a read-modify-write.
// One transaction at a time; the next one is taken while a result waits in the output
// register, and it holds in its final cycle until that result is accepted.
module vector_masked_add_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [2:0] req_type
  input  wire logic [2:0]                        s_tuser,
  // [4:0] dest_reg, [9:5] src_a_reg, [14:10] src_b_reg, [19:15] immediate,
  // [83:20] scalar_value, [84] unmasked, [88:85] byte_offset, [96:89] write_byte
  input  wire logic [vmau_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [7:0] read_byte, [8] done_res
  output logic      [vmau_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [2:0]                        cfg_index,
  input  wire logic [7:0]                        cfg_data
);

  import vmau_pkg::*;

  req_t       req;
  cmd_t       cmd;
  sts_t       sts;
  logic [7:0] read_byte;

  // Unpack the request transaction
  assign req.req_type     = op_t'(s_tuser);
  assign req.dest_reg     = s_tdata[4:0];
  assign req.src_a_reg    = s_tdata[9:5];
  assign req.src_b_reg    = s_tdata[14:10];
  assign req.immediate    = s_tdata[19:15];
  assign req.scalar_value = s_tdata[83:20];
  assign req.unmasked     = s_tdata[84];
  assign req.byte_offset  = s_tdata[88:85];
  assign req.write_byte   = s_tdata[96:89];

  assign m_tdata = {{(OUT_TDATA_W - 9){1'b0}}, 1'b1, read_byte};

  vmau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  vmau_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .read_byte (read_byte)
  );

endmodule

`default_nettype wire
